[rtl/dwp_pkg.sv]
// Types and constants shared by the dual-wheel position PID block.
`timescale 1ns / 1ps
`default_nettype none
package dwp_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 39;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PROP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_INTEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DERIV  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_PROP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_INTEG = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DERIV = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RPM     = 3'd7;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] target_left;
    logic signed [31:0] target_right;
    logic [14:0]        speed_limit;
    logic               pid_enable;
    logic signed [31:0] count_left;
    logic signed [31:0] count_right;
  } dwp_in_t;

  typedef struct packed {
    logic signed [15:0] drive_left;
    logic signed [15:0] drive_right;
    logic               reached_left;
    logic               reached_right;
    logic               move_done;
  } dwp_out_t;

  typedef struct packed {
    logic signed [31:0] prop;
    logic signed [31:0] integ;
    logic signed [31:0] deriv;
  } dwp_gain_t;

  typedef struct packed {
    logic signed [32:0] err;
    logic signed [39:0] integ;
    logic signed [33:0] diff;
  } dwp_opnd_t;

  typedef struct packed {
    logic               use_pid_l;
    logic               use_pid_r;
    logic signed [15:0] fixed_l;
    logic signed [15:0] fixed_r;
    logic [14:0]        speed_cap;
    logic               rl;
    logic               rr;
    logic               done;
  } dwp_ctl_t;

endpackage
`default_nettype wire

[rtl/dwp_state.sv]
// Move state, reached tests and PID operand preparation for both wheels.
`timescale 1ns / 1ps
`default_nettype none
module dwp_state import dwp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        ld,
  input  wire dwp_in_t     item,
  input  wire logic [38:0] integ_limit,
  output dwp_ctl_t         ctl_r,
  output dwp_opnd_t        opnd_l_r,
  output dwp_opnd_t        opnd_r_r
);

  logic signed [31:0] tgt_l_r, tgt_r_r;
  logic               fwd_l_r, fwd_r_r;
  logic [14:0]        cap_r;
  logic               mode_r;
  logic signed [39:0] integ_l_r, integ_r_r;
  logic signed [32:0] prev_l_r, prev_r_r;
  logic signed [15:0] drv_l_r, drv_r_r;
  logic signed [15:0] drv_l_nxt, drv_r_nxt;

  logic               is_tick, rl, rr, done, both_zero, pid_upd;
  logic signed [32:0] err_l, err_r;
  logic signed [39:0] i_l, i_r;
  logic signed [33:0] diff_l, diff_r;
  logic signed [40:0] lim;
  logic signed [15:0] cap_pos;
  logic signed [15:0] start_l, start_r;

  function automatic logic signed [39:0] clamp_integ(input logic signed [40:0] x,
                                                     input logic signed [40:0] m);
    logic signed [40:0] y;
    y = x;
    if (x > m) y = m;
    else if (x < -m) y = -m;
    return y[39:0];
  endfunction

  assign is_tick   = (item.command == CMD_TICK);
  assign rl        = fwd_l_r ? (tgt_l_r < item.count_left) : (tgt_l_r > item.count_left);
  assign rr        = fwd_r_r ? (tgt_r_r < item.count_right) : (tgt_r_r > item.count_right);
  assign done      = rl && rr;
  assign both_zero = (tgt_l_r == 32'sd0) && (tgt_r_r == 32'sd0);
  assign pid_upd   = is_tick && !done && !both_zero && mode_r;

  assign err_l  = {tgt_l_r[31], tgt_l_r} - {item.count_left[31], item.count_left};
  assign err_r  = {tgt_r_r[31], tgt_r_r} - {item.count_right[31], item.count_right};
  assign lim    = {2'b00, integ_limit};
  assign i_l    = clamp_integ({integ_l_r[39], integ_l_r} + {{8{err_l[32]}}, err_l}, lim);
  assign i_r    = clamp_integ({integ_r_r[39], integ_r_r} + {{8{err_r[32]}}, err_r}, lim);
  assign diff_l = {err_l[32], err_l} - {prev_l_r[32], prev_l_r};
  assign diff_r = {err_r[32], err_r} - {prev_r_r[32], prev_r_r};

  assign cap_pos = {1'b0, item.speed_limit};
  assign start_l = item.pid_enable ? 16'sd0 :
                   (item.target_left[31] ? -cap_pos : cap_pos);
  assign start_r = item.pid_enable ? 16'sd0 :
                   (item.target_right[31] ? -cap_pos : cap_pos);

  always_comb begin
    drv_l_nxt = drv_l_r;
    drv_r_nxt = drv_r_r;
    if (!is_tick) begin
      drv_l_nxt = start_l;
      drv_r_nxt = start_r;
    end else begin
      if (rl || (!done && both_zero)) drv_l_nxt = 16'sd0;
      if (rr || (!done && both_zero)) drv_r_nxt = 16'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_l_r   <= '0;
      tgt_r_r   <= '0;
      fwd_l_r   <= 1'b1;
      fwd_r_r   <= 1'b1;
      cap_r     <= '0;
      mode_r    <= 1'b0;
      integ_l_r <= '0;
      integ_r_r <= '0;
      prev_l_r  <= '0;
      prev_r_r  <= '0;
      drv_l_r   <= '0;
      drv_r_r   <= '0;
    end else if (ld) begin
      drv_l_r <= drv_l_nxt;
      drv_r_r <= drv_r_nxt;
      if (!is_tick) begin
        tgt_l_r   <= item.target_left;
        tgt_r_r   <= item.target_right;
        fwd_l_r   <= !item.target_left[31];
        fwd_r_r   <= !item.target_right[31];
        cap_r     <= item.speed_limit;
        mode_r    <= item.pid_enable;
        integ_l_r <= '0;
        integ_r_r <= '0;
        prev_l_r  <= '0;
        prev_r_r  <= '0;
      end else if (pid_upd) begin
        integ_l_r <= i_l;
        integ_r_r <= i_r;
        prev_l_r  <= err_l;
        prev_r_r  <= err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ctl_r.use_pid_l <= pid_upd && !rl;
      ctl_r.use_pid_r <= pid_upd && !rr;
      ctl_r.fixed_l   <= drv_l_nxt;
      ctl_r.fixed_r   <= drv_r_nxt;
      ctl_r.speed_cap <= cap_r;
      ctl_r.rl        <= is_tick && rl;
      ctl_r.rr        <= is_tick && rr;
      ctl_r.done      <= is_tick && done;
      opnd_l_r.err    <= err_l;
      opnd_l_r.integ  <= i_l;
      opnd_l_r.diff   <= diff_l;
      opnd_r_r.err    <= err_r;
      opnd_r_r.integ  <= i_r;
      opnd_r_r.diff   <= diff_r;
    end
  end

endmodule
`default_nettype wire

[rtl/dwp_pid_side.sv]
// Gain products, exact sum, rounding and speed clamps for one wheel.
`timescale 1ns / 1ps
`default_nettype none
module dwp_pid_side import dwp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        ld_mul,
  input  wire logic        ld_sum,
  input  wire dwp_opnd_t   opnd,
  input  wire dwp_gain_t   gain,
  input  wire logic [14:0] max_rpm,
  input  wire logic [14:0] speed_cap,
  output logic signed [15:0] drive
);

  localparam logic signed [74:0] POS_LIM = 75'sh100_0000_0000;
  localparam logic signed [74:0] NEG_LIM = -POS_LIM;
  localparam logic signed [41:0] HALF_LSB = 42'sd524288;

  logic signed [64:0] pe_r;
  logic signed [52:0] pil_r;
  logic signed [51:0] pih_r;
  logic signed [65:0] pd_r;
  logic signed [74:0] sum_r;
  logic signed [74:0] sum_nxt;
  logic signed [74:0] sat;
  logic signed [41:0] rnd;
  logic signed [21:0] rpm, m_max, m_cap, c1, c2;

  always_ff @(posedge clk) begin
    if (ld_mul) begin
      pe_r  <= opnd.err * gain.prop;
      pil_r <= $signed({1'b0, opnd.integ[19:0]}) * gain.integ;
      pih_r <= $signed(opnd.integ[39:20]) * gain.integ;
      pd_r  <= opnd.diff * gain.deriv;
    end
  end

  assign sum_nxt = {{10{pe_r[64]}}, pe_r} + {{3{pih_r[51]}}, pih_r, 20'd0}
                 + {{22{pil_r[52]}}, pil_r} + {{9{pd_r[65]}}, pd_r};

  always_ff @(posedge clk) begin
    if (ld_sum) sum_r <= sum_nxt;
  end

  always_comb begin
    sat = sum_r;
    if (sum_r > POS_LIM) sat = POS_LIM;
    else if (sum_r < NEG_LIM) sat = NEG_LIM;
    rnd   = sat[41:0] + HALF_LSB;
    rpm   = rnd[41:20];
    m_max = {7'd0, max_rpm};
    m_cap = {7'd0, speed_cap};
    c1 = rpm;
    if (rpm < -m_max) c1 = -m_max;
    if (c1 > m_max) c1 = m_max;
    c2 = c1;
    if (c1 < -m_cap) c2 = -m_cap;
    if (c2 > m_cap) c2 = m_cap;
    drive = c2[15:0];
  end

endmodule
`default_nettype wire

[rtl/dual_wheel_position_pid_top.sv]
// Top level of the dual-wheel position PID: ports, registers, pipeline control.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready   | dwp_in_t in_data
//  out     | output    | out_valid/out_ready | dwp_out_t out_data
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle while out_ready does not stall the output; each result passes
// through the state, product, sum and output registers behind the input register.
// The gain products and their sum set the stage split.
// rst_n clears the valid bits, the move state and the settings synchronously.
// A stall on out_ready holds the output; empty stages behind it still fill.
`timescale 1ns / 1ps
`default_nettype none
module dual_wheel_position_pid_top import dwp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire dwp_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output dwp_out_t                   out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  dwp_gain_t   gain_l_r, gain_r_r;
  logic [38:0] integ_limit_r;
  logic [14:0] max_rpm_r;

  dwp_in_t   in_r;
  logic      v0_r, v1_r, v2_r, v3_r, out_valid_r;
  dwp_out_t  out_data_r;
  dwp_ctl_t  ctl1, ctl2_r, ctl3_r;
  dwp_opnd_t opnd_l, opnd_r;
  logic signed [15:0] pid_l, pid_r;
  logic      free0, free1, free2, free3, free_o;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_l_r      <= '0;
      gain_r_r      <= '0;
      integ_limit_r <= '0;
      max_rpm_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEFT_PROP:   gain_l_r.prop  <= cfg_data[31:0];
        REG_LEFT_INTEG:  gain_l_r.integ <= cfg_data[31:0];
        REG_LEFT_DERIV:  gain_l_r.deriv <= cfg_data[31:0];
        REG_RIGHT_PROP:  gain_r_r.prop  <= cfg_data[31:0];
        REG_RIGHT_INTEG: gain_r_r.integ <= cfg_data[31:0];
        REG_RIGHT_DERIV: gain_r_r.deriv <= cfg_data[31:0];
        REG_INTEG_LIMIT: integ_limit_r  <= cfg_data[38:0];
        REG_MAX_RPM:     max_rpm_r      <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  assign free_o   = !out_valid_r || out_ready;
  assign free3    = !v3_r || free_o;
  assign free2    = !v2_r || free3;
  assign free1    = !v1_r || free2;
  assign free0    = !v0_r || free1;
  assign in_ready = free0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (free0)  v0_r        <= in_valid;
      if (free1)  v1_r        <= v0_r;
      if (free2)  v2_r        <= v1_r;
      if (free3)  v3_r        <= v2_r;
      if (free_o) out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (free0 && in_valid) in_r <= in_data;
    if (free2 && v1_r) ctl2_r <= ctl1;
    if (free3 && v2_r) ctl3_r <= ctl2_r;
  end

  dwp_state u_state (
    .clk         (clk),
    .rst_n       (rst_n),
    .ld          (free1 && v0_r),
    .item        (in_r),
    .integ_limit (integ_limit_r),
    .ctl_r       (ctl1),
    .opnd_l_r    (opnd_l),
    .opnd_r_r    (opnd_r)
  );

  dwp_pid_side u_pid_l (
    .clk       (clk),
    .ld_mul    (free2 && v1_r),
    .ld_sum    (free3 && v2_r),
    .opnd      (opnd_l),
    .gain      (gain_l_r),
    .max_rpm   (max_rpm_r),
    .speed_cap (ctl3_r.speed_cap),
    .drive     (pid_l)
  );

  dwp_pid_side u_pid_r (
    .clk       (clk),
    .ld_mul    (free2 && v1_r),
    .ld_sum    (free3 && v2_r),
    .opnd      (opnd_r),
    .gain      (gain_r_r),
    .max_rpm   (max_rpm_r),
    .speed_cap (ctl3_r.speed_cap),
    .drive     (pid_r)
  );

  always_ff @(posedge clk) begin
    if (free_o && v3_r) begin
      out_data_r.drive_left    <= ctl3_r.use_pid_l ? pid_l : ctl3_r.fixed_l;
      out_data_r.drive_right   <= ctl3_r.use_pid_r ? pid_r : ctl3_r.fixed_r;
      out_data_r.reached_left  <= ctl3_r.rl;
      out_data_r.reached_right <= ctl3_r.rr;
      out_data_r.move_done     <= ctl3_r.done;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.move_done |->
      out_data.drive_left == 16'sd0 && out_data.drive_right == 16'sd0 &&
      out_data.reached_left && out_data.reached_right)
    else $error("move done with non-zero drive or unreached wheel");

  a_both_reached: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reached_left && out_data.reached_right |-> out_data.move_done)
    else $error("both wheels reached without move done");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v0_r && v1_r && v2_r && v3_r && out_valid_r && !out_ready)
    else $error("input held off while the pipeline has room");

endmodule
`default_nettype wire

[bench/tb_dual_wheel_position_pid_top.sv]
// Self-checking testbench for the dual-wheel position PID top with a drive predictor.
`timescale 1ns / 1ps
module tb_dual_wheel_position_pid_top import dwp_pkg::*;;

  localparam int HOLD_CYCLES = 300;
  localparam logic signed [127:0] SUM_CAP = 128'sd1 <<< 40;

  typedef struct {
    logic [CFG_DATA_W-1:0] kp_l, ki_l, kd_l, kp_r, ki_r, kd_r, ilim, max_rpm;
  } pid_settings_t;

  class drive_tracker;
    logic signed [31:0] gain [6];
    longint ilim, max_rpm;
    longint tgt_l, tgt_r, cap;
    bit fwd_l = 1'b1, fwd_r = 1'b1, pid_on;
    longint integ_l, integ_r, prev_l, prev_r, drv_l, drv_r;
    dwp_out_t expected_drives[$];
    int failures;

    function new();
      foreach (gain[k]) gain[k] = '0;
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_LEFT_PROP, REG_LEFT_INTEG, REG_LEFT_DERIV,
        REG_RIGHT_PROP, REG_RIGHT_INTEG, REG_RIGHT_DERIV: gain[idx] = val[31:0];
        REG_INTEG_LIMIT: ilim = val;
        REG_MAX_RPM: max_rpm = val[14:0];
        default: ;
      endcase
    endfunction

    function logic signed [127:0] wide_mul(longint a, logic signed [31:0] b);
      logic signed [127:0] x, y;
      x = a;
      y = b;
      return x * y;
    endfunction

    function longint to_q4(logic signed [127:0] sum);
      longint v;
      if (sum > SUM_CAP) v = 64'sd1 <<< 40;
      else if (sum < -SUM_CAP) v = -(64'sd1 <<< 40);
      else v = sum[63:0];
      return (v + 64'sd524288) >>> 20;
    endfunction

    function longint pid_wheel(longint err, inout longint integ, inout longint prev,
                               input logic signed [31:0] kp, ki, kd);
      longint acc, q;
      logic signed [127:0] sum;
      acc = integ + err;
      if (acc < -ilim) acc = -ilim;
      if (acc > ilim) acc = ilim;
      sum = wide_mul(err, kp) + wide_mul(acc, ki) + wide_mul(err - prev, kd);
      integ = acc;
      prev = err;
      q = to_q4(sum);
      if (q < -max_rpm) q = -max_rpm;
      if (q > max_rpm) q = max_rpm;
      if (q < -cap) q = -cap;
      if (q > cap) q = cap;
      return q;
    endfunction

    function void accept_command(dwp_in_t it);
      dwp_out_t want;
      bit rl, rr, done;
      longint cl, cr, dl, dr;
      rl = 1'b0;
      rr = 1'b0;
      done = 1'b0;
      if (it.command == CMD_START) begin
        tgt_l = it.target_left;
        tgt_r = it.target_right;
        cap = it.speed_limit;
        pid_on = it.pid_enable;
        fwd_l = tgt_l >= 0;
        fwd_r = tgt_r >= 0;
        integ_l = 0;
        integ_r = 0;
        prev_l = 0;
        prev_r = 0;
        if (pid_on) begin
          drv_l = 0;
          drv_r = 0;
        end else begin
          drv_l = fwd_l ? cap : -cap;
          drv_r = fwd_r ? cap : -cap;
        end
      end else begin
        cl = it.count_left;
        cr = it.count_right;
        rl = fwd_l ? (cl > tgt_l) : (cl < tgt_l);
        rr = fwd_r ? (cr > tgt_r) : (cr < tgt_r);
        if (rl) drv_l = 0;
        if (rr) drv_r = 0;
        if (rl && rr) begin
          done = 1'b1;
        end else if (tgt_l == 0 && tgt_r == 0) begin
          drv_l = 0;
          drv_r = 0;
        end else if (pid_on) begin
          dl = pid_wheel(tgt_l - cl, integ_l, prev_l, gain[REG_LEFT_PROP],
                         gain[REG_LEFT_INTEG], gain[REG_LEFT_DERIV]);
          dr = pid_wheel(tgt_r - cr, integ_r, prev_r, gain[REG_RIGHT_PROP],
                         gain[REG_RIGHT_INTEG], gain[REG_RIGHT_DERIV]);
          if (!rl) drv_l = dl;
          if (!rr) drv_r = dr;
        end
      end
      want.drive_left = drv_l[15:0];
      want.drive_right = drv_r[15:0];
      want.reached_left = rl;
      want.reached_right = rr;
      want.move_done = done;
      expected_drives.push_back(want);
    endfunction

    function void compare_drive(dwp_out_t got);
      dwp_out_t want;
      if (expected_drives.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: L %0d R %0d rl %0b rr %0b done %0b",
                   got.drive_left, got.drive_right, got.reached_left,
                   got.reached_right, got.move_done);
        return;
      end
      want = expected_drives.pop_front();
      if (got.drive_left !== want.drive_left || got.drive_right !== want.drive_right ||
          got.reached_left !== want.reached_left ||
          got.reached_right !== want.reached_right || got.move_done !== want.move_done) begin
        failures++;
        if (failures <= 10)
          $display("drive mismatch: expected L %0d R %0d rl %0b rr %0b done %0b, got L %0d R %0d rl %0b rr %0b done %0b",
                   want.drive_left, want.drive_right, want.reached_left,
                   want.reached_right, want.move_done, got.drive_left, got.drive_right,
                   got.reached_left, got.reached_right, got.move_done);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  dwp_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dwp_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit steady_feed, steady_sink, hold_off_req;
  drive_tracker sb;

  dual_wheel_position_pid_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.compare_drive(out_data);
  end

  function automatic int pick_gap(bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] to_count(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint pick_target();
    longint mag;
    case ($urandom_range(0, 7))
      0: return 0;
      1: return $signed($urandom);
      2: return $urandom_range(0, 1) ? 64'sd2147483647 : -64'sd2147483648;
      default: begin
        mag = $urandom_range(0, 5000);
        return $urandom_range(0, 1) ? mag : -mag;
      end
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain(int top);
    logic signed [31:0] g;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = 32'sh7FFFFFFF;
      2: g = 32'sh80000000;
      3: g = $urandom;
      default: begin
        g = $urandom_range(0, 1 << top);
        if ($urandom_range(0, 1)) g = -g;
      end
    endcase
    return {7'd0, g};
  endfunction

  function automatic pid_settings_t pick_settings();
    pid_settings_t s;
    s.kp_l = pick_gain(22);
    s.ki_l = pick_gain(14);
    s.kd_l = pick_gain(20);
    s.kp_r = pick_gain(22);
    s.ki_r = pick_gain(14);
    s.kd_r = pick_gain(20);
    case ($urandom_range(0, 3))
      0: s.ilim = '0;
      1: s.ilim = {CFG_DATA_W{1'b1}};
      2: s.ilim = CFG_DATA_W'($urandom_range(0, 20000));
      default: s.ilim = CFG_DATA_W'({$urandom, $urandom});
    endcase
    case ($urandom_range(0, 4))
      0: s.max_rpm = '0;
      1: s.max_rpm = 39'h7FFF;
      2: s.max_rpm = CFG_DATA_W'($urandom_range(0, 2000));
      default: s.max_rpm = CFG_DATA_W'($urandom_range(0, 32767));
    endcase
    return s;
  endfunction

  function automatic dwp_in_t make_start(longint tl, longint tr, int spd, bit pid);
    dwp_in_t it;
    it.command = CMD_START;
    it.target_left = tl[31:0];
    it.target_right = tr[31:0];
    it.speed_limit = spd[14:0];
    it.pid_enable = pid;
    it.count_left = $urandom;
    it.count_right = $urandom;
    return it;
  endfunction

  function automatic dwp_in_t make_tick(longint cl, longint cr);
    dwp_in_t it;
    it.command = CMD_TICK;
    it.target_left = $urandom;
    it.target_right = $urandom;
    it.speed_limit = 15'($urandom);
    it.pid_enable = 1'($urandom);
    it.count_left = cl[31:0];
    it.count_right = cr[31:0];
    return it;
  endfunction

  task automatic send_item(input dwp_in_t item);
    int gap;
    gap = pick_gap(steady_feed);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= item;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.accept_command(item);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic load_settings(input pid_settings_t s);
    write_reg(REG_LEFT_PROP, s.kp_l);
    write_reg(REG_LEFT_INTEG, s.ki_l);
    write_reg(REG_LEFT_DERIV, s.kd_l);
    write_reg(REG_RIGHT_PROP, s.kp_r);
    write_reg(REG_RIGHT_INTEG, s.ki_r);
    write_reg(REG_RIGHT_DERIV, s.kd_r);
    write_reg(REG_INTEG_LIMIT, s.ilim);
    write_reg(REG_MAX_RPM, s.max_rpm);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_moves(input int n_items);
    int sent, kind, step_k, jit_l, jit_r;
    longint tl, tr, cl, cr;
    dwp_in_t junk;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        junk.command = $urandom_range(0, 1) ? CMD_TICK : CMD_START;
        junk.target_left = $urandom;
        junk.target_right = $urandom;
        junk.speed_limit = 15'($urandom);
        junk.pid_enable = 1'($urandom);
        junk.count_left = $urandom;
        junk.count_right = $urandom;
        send_item(junk);
        sent++;
      end else begin
        tl = pick_target();
        tr = pick_target();
        send_item(make_start(tl, tr, $urandom_range(0, 32767), $urandom_range(0, 3) != 0));
        sent++;
        cl = 0;
        cr = 0;
        repeat ($urandom_range(1, 25)) begin
          if (kind == 1) begin
            cl = $signed($urandom);
            cr = $signed($urandom);
          end else begin
            step_k = $urandom_range(1, 6);
            jit_l = $urandom_range(0, 80) - 40;
            jit_r = $urandom_range(0, 80) - 40;
            cl = to_count(cl + (tl - cl) * step_k / 4 + jit_l);
            cr = to_count(cr + (tr - cr) * step_k / 4 + jit_r);
          end
          send_item(make_tick(cl, cr));
          sent++;
        end
      end
    end
  endtask

  initial begin : sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (steady_sink || $urandom_range(0, 3) != 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat (1 + pick_gap(1'b0)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(64'd8_000_000);
    $display("tb_dual_wheel_position_pid_top failed");
    $finish;
  end

  initial begin : stimulus
    pid_settings_t s;
    sb = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    s.kp_l = 39'd1048576;
    s.ki_l = 39'd4096;
    s.kd_l = 39'd262144;
    s.kp_r = 39'd2097152;
    s.ki_r = {7'd0, -32'sd8192};
    s.kd_r = {7'd0, -32'sd131072};
    s.ilim = 39'd5000;
    s.max_rpm = 39'd30000;
    load_settings(s);

    steady_feed = 1'b1;
    send_item(make_tick(0, 0));
    send_item(make_tick(1, -1));
    send_item(make_tick(5, 5));
    send_item(make_start(1000, -1000, 32767, 1'b0));
    send_item(make_tick(500, -1001));
    send_item(make_tick(500, -500));
    send_item(make_tick(1001, -1001));
    send_item(make_start(64'sd2147483647, -64'sd2147483648, 0, 1'b0));
    send_item(make_tick(-64'sd2147483648, 64'sd2147483647));
    send_item(make_tick(64'sd2147483647, -64'sd2147483648));
    send_item(make_start(3000, -3000, 32767, 1'b1));
    send_item(make_tick(0, 0));
    send_item(make_tick(1000, -1000));
    send_item(make_tick(3001, -2000));
    send_item(make_tick(2500, -2500));
    send_item(make_tick(3001, -3001));
    send_item(make_tick(0, 0));
    send_item(make_start(0, 0, 20000, 1'b1));
    send_item(make_tick(-1, -1));
    send_item(make_tick(-64'sd2147483648, 64'sd2147483647));
    send_item(make_start(-5, 7, 12345, 1'b0));
    send_item(make_tick(-6, 8));
    send_item(make_start(-64'sd2147483648, 64'sd2147483647, 32767, 1'b1));
    send_item(make_tick(-64'sd2147483648, 64'sd2147483647));
    send_item(make_tick(64'sd2147483647, -64'sd2147483648));
    steady_feed = 1'b0;
    drain();

    for (int p = 0; p < 7; p++) begin
      s = pick_settings();
      if (p == 0) begin
        s.kp_l = 39'h007FFFFFFF;
        s.ki_l = 39'h0080000000;
        s.kd_l = 39'h007FFFFFFF;
        s.kp_r = 39'h0080000000;
        s.ki_r = 39'h007FFFFFFF;
        s.kd_r = 39'h0080000000;
        s.ilim = {CFG_DATA_W{1'b1}};
        s.max_rpm = 39'h7FFF;
      end else if (p == 1) begin
        s.ilim = '0;
        s.max_rpm = '0;
      end
      load_settings(s);
      steady_feed = (p == 2);
      steady_sink = (p == 2);
      if (p == 3) hold_off_req = 1'b1;
      run_moves(240);
      drain();
    end

    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("tb_dual_wheel_position_pid_top passed");
    end else begin
      $display("tb_dual_wheel_position_pid_top failed");
    end
    $finish;
  end

endmodule

[dual_wheel_position_pid_top.f]
rtl/dwp_pkg.sv
rtl/dwp_state.sv
rtl/dwp_pid_side.sv
rtl/dual_wheel_position_pid_top.sv
bench/tb_dual_wheel_position_pid_top.sv
